// ----- rtl/complex_moving_average_replicated_edges_assert.svh -----
// Assertion macros for the moving average block.
// Each macro expects clk and arst_n in scope.
`ifndef COMPLEX_MOVING_AVERAGE_REPLICATED_EDGES_ASSERT_SVH
`define COMPLEX_MOVING_AVERAGE_REPLICATED_EDGES_ASSERT_SVH
`ifndef SYNTHESIS
`define CMARE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CMARE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CMARE_ASSERT(lbl, prop, msg)
`define CMARE_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/cmare_pkg.sv -----
package cmare_pkg;

	// position counters (samples_seen, outputs_given, pushes)
	localparam int CNT_W = 7;
	localparam int HW_W = 5;
	localparam int SCALE_W = 16;
	localparam int CFG_DATA_W = 16;

	typedef logic [0:0] cfg_idx_t;

	localparam cfg_idx_t REG_HALF_WIDTH = 1'b0;
	localparam cfg_idx_t REG_RECIP_SCALE = 1'b1;

	localparam logic [HW_W-1:0] HALF_WIDTH_RST = 5'd1;
	localparam logic [SCALE_W-1:0] RECIP_SCALE_RST = 16'd21845;

endpackage

// ----- rtl/complex_moving_average_replicated_edges.sv -----
// Channel   Dir  Handshake             Payload
// s_*       in   s_tvalid/s_tready     s_tdata {sample_im, sample_re}, s_tlast = line_end
// m_*       out  m_tvalid/m_tready     m_tdata {mean_im, mean_re}, m_tlast = line_done,
//                                      m_tuser = run_last
// cfg_*     in   cfg_valid/cfg_ready   cfg_index (0 half_width, 1 reciprocal_scale), cfg_data
//
// Steps: a sample that gives a result passes preset, multiply and deliver if it opens a line,
// and window read, running-sum update, multiply and deliver otherwise. Each of the h copies
// replayed at line end repeats update, multiply and deliver; without a result, no deliver.
// Reset: arst_n clears the sequencer, counters, sums and config; the window memory needs no clear.
// Stalls: a held result blocks only the next delivery; a new item is taken while the last result
// of the previous one waits. A config write is taken only between items and holds off the input.

module complex_moving_average_replicated_edges
	import cmare_pkg::*;
#(
	parameter int MAX_HALF = 31,
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// [SAMPLE_BITS-1:0] sample_re, [2*SAMPLE_BITS-1:SAMPLE_BITS] sample_im, zero pad above
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	input  logic s_tlast,

	output logic m_tvalid,
	input  logic m_tready,
	// [SAMPLE_BITS-1:0] mean_re, [2*SAMPLE_BITS-1:SAMPLE_BITS] mean_im, zero pad above
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	output logic m_tlast,
	// [0] run_last
	output logic m_tuser,

	input  logic cfg_valid,
	output logic cfg_ready,
	input  cfg_idx_t cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = 2*MAX_HALF + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int DIFF_W = CNT_W + 1;
	localparam int DATA_W = ((2*SAMPLE_BITS+7)/8)*8;
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int PROD_W = SUM_W + SCALE_W + 1;
	localparam int FIRST_W = SAMPLE_BITS + CNT_W + 1;
	localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(2**(SCALE_W-1));
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(2**(SAMPLE_BITS-1) - 1);
	localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PUSH = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;

	// configuration
	logic [HW_W-1:0] half_width_q;
	logic [SCALE_W-1:0] recip_q;

	// window memory: one entry per pushed position, {im, re}
	logic [2*SAMPLE_BITS-1:0] win_mem [DEPTH];
	logic [2*SAMPLE_BITS-1:0] rd_data_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rd_addr;
	logic [DIFF_W-1:0] rd_diff;
	logic rd_en;

	// line state
	logic in_line_q;
	logic last_q;
	logic signed [SAMPLE_BITS-1:0] x_re_q, x_im_q;
	logic signed [SAMPLE_BITS-1:0] x0_re_q, x0_im_q;
	logic signed [SUM_W-1:0] sum_re_q, sum_im_q;
	logic [CNT_W-1:0] seen_q, given_q, pc_q, flush_q;

	// multiply stage
	logic signed [PROD_W-1:0] prod_re_s1, prod_im_s1;

	// output register
	logic m_tvalid_q;
	logic signed [SAMPLE_BITS-1:0] mean_re_q, mean_im_q;
	logic line_done_q, run_last_q;

	// derived control
	logic [CNT_W-1:0] h_eff, h_p1, two_h1, pending;
	logic s_accept, emit, out_free, out_load, step_done, flush_go;
	logic signed [SAMPLE_BITS-1:0] s_re, s_im, sub_re, sub_im, rd_re, rd_im;
	logic signed [FIRST_W-1:0] first_re, first_im;

	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-1:0] v;
		v = (p + ROUND_C) >>> SCALE_W;
		if (v > SAT_HI) begin
			v = SAT_HI;
		end else if (v < SAT_LO) begin
			v = SAT_LO;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	// half width above MAX_HALF acts as MAX_HALF
	assign h_eff = (CNT_W'(half_width_q) > CNT_W'(MAX_HALF)) ? CNT_W'(MAX_HALF)
		: CNT_W'(half_width_q);
	assign h_p1 = h_eff + 1'b1;
	assign two_h1 = {h_eff[CNT_W-2:0], 1'b1};
	assign pending = seen_q - given_q;

	assign s_re = s_tdata[SAMPLE_BITS-1:0];
	assign s_im = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign rd_re = rd_data_q[SAMPLE_BITS-1:0];
	assign rd_im = rd_data_q[2*SAMPLE_BITS-1:SAMPLE_BITS];

	// first sample presets the window with h+1 copies of itself
	assign first_re = s_re * $signed({1'b0, h_p1});
	assign first_im = s_im * $signed({1'b0, h_p1});

	// take config only between items; a pending write goes ahead of the next item
	assign cfg_ready = (state_q == ST_IDLE);
	assign s_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign s_accept = s_tvalid && s_tready;

	assign emit = (pending > h_eff);
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign step_done = ((state_q == ST_EMIT) && !emit) || out_load;
	assign flush_go = step_done && (flush_q != '0);
	assign rd_en = (s_accept && in_line_q) || flush_go;

	// oldest entry of the window sits 2h+1 pushes behind the write pointer
	assign rd_diff = DIFF_W'(wp_q) - DIFF_W'(two_h1);
	assign rd_addr = rd_diff[DIFF_W-1] ? AW'(rd_diff + DIFF_W'(DEPTH)) : AW'(rd_diff);

	// Value dropped by this push: zero padding for the first h pushes of a line,
	// then the replicated first sample, then real entries from memory.
	always_comb begin
		priority if (pc_q < h_eff) begin
			sub_re = '0;
			sub_im = '0;
		end else if (pc_q < two_h1) begin
			sub_re = x0_re_q;
			sub_im = x0_im_q;
		end else begin
			sub_re = rd_re;
			sub_im = rd_im;
		end
	end

	// Reads and writes never share a cycle: reads happen on accept or step end,
	// the write only in the push state.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= win_mem[rd_addr];
		end
		if (state_q == ST_PUSH) begin
			win_mem[wp_q] <= {x_im_q, x_re_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_WIDTH_RST;
			recip_q <= RECIP_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HALF_WIDTH: begin
					half_width_q <= cfg_data[HW_W-1:0];
				end
				REG_RECIP_SCALE: begin
					recip_q <= cfg_data[SCALE_W-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			x_re_q <= s_re;
			x_im_q <= s_im;
			last_q <= s_tlast;
			if (!in_line_q) begin
				x0_re_q <= s_re;
				x0_im_q <= s_im;
			end
		end
		if ((state_q == ST_EMIT) && emit) begin
			prod_re_s1 <= sum_re_q * $signed({1'b0, recip_q});
			prod_im_s1 <= sum_im_q * $signed({1'b0, recip_q});
		end
		if (out_load) begin
			mean_re_q <= round_sat(prod_re_s1);
			mean_im_q <= round_sat(prod_im_s1);
			run_last_q <= (flush_q == '0);
			line_done_q <= last_q && (flush_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_line_q <= 1'b0;
			sum_re_q <= '0;
			sum_im_q <= '0;
			seen_q <= '0;
			given_q <= '0;
			pc_q <= '0;
			flush_q <= '0;
			wp_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						flush_q <= s_tlast ? h_eff : '0;
						if (in_line_q) begin
							state_q <= ST_PUSH;
						end else begin
							// preset the window and open the line
							sum_re_q <= SUM_W'(first_re);
							sum_im_q <= SUM_W'(first_im);
							seen_q <= CNT_W'(1);
							given_q <= '0;
							pc_q <= '0;
							in_line_q <= 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_PUSH: begin
					// add the newest, drop the oldest
					sum_re_q <= sum_re_q - SUM_W'(sub_re) + SUM_W'(x_re_q);
					sum_im_q <= sum_im_q - SUM_W'(sub_im) + SUM_W'(x_im_q);
					seen_q <= seen_q + 1'b1;
					if (pc_q != '1) begin
						pc_q <= pc_q + 1'b1;
					end
					wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// the line close below resets the count instead
					if (out_free && !(last_q && (flush_q == '0))) begin
						given_q <= given_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// step finished: replicate the last sample again or close the item
			if (step_done) begin
				if (flush_q != '0) begin
					flush_q <= flush_q - 1'b1;
					state_q <= ST_PUSH;
				end else begin
					state_q <= ST_IDLE;
					if (last_q) begin
						sum_re_q <= '0;
						sum_im_q <= '0;
						seen_q <= '0;
						given_q <= '0;
						pc_q <= '0;
						in_line_q <= 1'b0;
					end
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = DATA_W'({mean_im_q, mean_re_q});
	assign m_tlast = line_done_q;
	assign m_tuser = run_last_q;

`include "complex_moving_average_replicated_edges_assert.svh"

	`CMARE_ASSERT(a_done_is_run_last, (m_tvalid && m_tlast) |-> m_tuser, "line end result not last of its item")
	`CMARE_ASSERT(a_idle_no_flush, (state_q == ST_IDLE) |-> (flush_q == '0), "flush count left at idle")
	`CMARE_NEVER(a_rd_wr_apart, rd_en && (state_q == ST_PUSH), "window read and write in one cycle")
	`CMARE_NEVER(a_out_no_overrun, out_load && m_tvalid_q && !m_tready, "output register overwritten")
	`CMARE_ASSERT(a_push_in_line, (state_q == ST_PUSH) |-> in_line_q, "push outside a line")

endmodule
